// ===== rtl/jsu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and helpers for the JSON string unescaper
// Holds the scan state, the per-request result bundle, mode codes and the
// hex-digit and UTF-8 encoding helpers.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_ESC   = 2'd1;
  localparam logic [1:0] MODE_HEX   = 2'd2;

  localparam logic [1:0] HEX_LAST_POS = 2'd3;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [15:0] CP_ONE_BYTE_MAX = 16'h007F;
  localparam logic [15:0] CP_TWO_BYTE_MAX = 16'h07FF;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  pos;
    logic [15:0] cp;
    logic        stopped;
    logic        drop;
  } scan_state_t;

  // Up to three result bytes produced by one request.
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
    logic            valid;
    logic            err;
    logic            last;
  } bundle_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
  } utf8_t;

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t h;
    logic [7:0] d;
    h = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      h.ok = 1'b1;
      h.val = d[3:0];
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      h.ok = 1'b1;
      h.val = d[3:0];
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      h.ok = 1'b1;
      h.val = d[3:0];
    end
    return h;
  endfunction

  function automatic utf8_t utf8_encode(input logic [15:0] cp);
    utf8_t u;
    u = '0;
    if (cp <= CP_ONE_BYTE_MAX) begin
      u.cnt = 2'd1;
      u.bytes[0] = cp[7:0];
    end else if (cp <= CP_TWO_BYTE_MAX) begin
      u.cnt = 2'd2;
      u.bytes[0] = {3'b110, cp[10:6]};
      u.bytes[1] = {2'b10, cp[5:0]};
    end else begin
      u.cnt = 2'd3;
      u.bytes[0] = {4'b1110, cp[15:12]};
      u.bytes[1] = {2'b10, cp[11:6]};
      u.bytes[2] = {2'b10, cp[5:0]};
    end
    return u;
  endfunction

endpackage

// ===== rtl/jsu_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_in_if / jsu_out_if: valid/ready channels of the JSON string unescaper
// The input channel carries raw string bytes, the output channel the
// decoded bytes with their status flags.
// ----------------------------------------------------------------------------
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       string_end;

  modport source (output valid, output char_in, output string_end, input ready);
  modport sink   (input valid, input char_in, input string_end, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       escape_error;
  logic       string_done;
  logic       run_last;

  modport source (output valid, output out_byte, output byte_valid,
                  output escape_error, output string_done, output run_last,
                  input ready);
  modport sink   (input valid, input out_byte, input byte_valid,
                  input escape_error, input string_done, input run_last,
                  output ready);
endinterface

// ===== rtl/jsu_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_decode: next-state and result logic for one input byte
// Given the scan state and one byte, computes the following state and the
// bundle of up to three result bytes that the byte produces.
// ----------------------------------------------------------------------------
module jsu_decode (
  input  jsu_pkg::scan_state_t st,
  input  logic [7:0]           char_in,
  input  logic                 string_end,
  output jsu_pkg::scan_state_t st_nxt,
  output jsu_pkg::bundle_t     bun
);
  import jsu_pkg::*;

  hex_t        hx;
  logic [15:0] cp_acc;
  utf8_t       enc_acc;
  utf8_t       enc_zero;

  assign hx       = hex_value(char_in);
  assign cp_acc   = (!st.stopped && hx.ok) ? {st.cp[11:0], hx.val} : st.cp;
  assign enc_acc  = utf8_encode(cp_acc);
  assign enc_zero = utf8_encode(16'h0000);

  always_comb begin
    st_nxt    = st;
    bun       = '0;
    bun.valid = 1'b1;
    bun.last  = string_end;

    if (st.drop) begin
      if (string_end) begin
        bun.cnt   = 2'd1;
        bun.valid = 1'b0;
      end
    end else begin
      unique case (st.mode)
        MODE_ESC: begin
          st_nxt.mode = MODE_PLAIN;
          unique case (char_in)
            CH_QUOTE, CH_BSLASH, CH_SLASH: begin
              bun.cnt = 2'd1;
              bun.bytes[0] = char_in;
            end
            CH_B: begin bun.cnt = 2'd1; bun.bytes[0] = 8'h08; end
            CH_F: begin bun.cnt = 2'd1; bun.bytes[0] = 8'h0C; end
            CH_N: begin bun.cnt = 2'd1; bun.bytes[0] = 8'h0A; end
            CH_R: begin bun.cnt = 2'd1; bun.bytes[0] = 8'h0D; end
            CH_T: begin bun.cnt = 2'd1; bun.bytes[0] = 8'h09; end
            CH_U: begin
              st_nxt.mode    = MODE_HEX;
              st_nxt.pos     = 2'd0;
              st_nxt.cp      = 16'h0000;
              st_nxt.stopped = 1'b0;
              if (string_end) begin
                bun.cnt   = enc_zero.cnt;
                bun.bytes = enc_zero.bytes;
              end
            end
            default: begin
              bun.cnt     = 2'd1;
              bun.valid   = 1'b0;
              bun.err     = 1'b1;
              st_nxt.drop = 1'b1;
            end
          endcase
        end
        MODE_HEX: begin
          st_nxt.cp      = cp_acc;
          st_nxt.stopped = st.stopped | ~hx.ok;
          if (st.pos == HEX_LAST_POS || string_end) begin
            bun.cnt        = enc_acc.cnt;
            bun.bytes      = enc_acc.bytes;
            st_nxt.mode    = MODE_PLAIN;
            st_nxt.pos     = 2'd0;
            st_nxt.cp      = 16'h0000;
            st_nxt.stopped = 1'b0;
          end else begin
            st_nxt.pos = st.pos + 2'd1;
          end
        end
        default: begin
          // Plain copy, also taken for the unused mode code.
          st_nxt.mode = MODE_PLAIN;
          if (char_in == CH_BSLASH) begin
            if (string_end) begin
              bun.cnt   = 2'd1;
              bun.valid = 1'b0;
              bun.err   = 1'b1;
            end else begin
              st_nxt.mode = MODE_ESC;
            end
          end else begin
            bun.cnt = 2'd1;
            bun.bytes[0] = char_in;
          end
        end
      endcase
    end

    if (string_end) begin
      st_nxt = '0;
    end
  end

endmodule

// ===== rtl/json_string_unescape_utf8.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8: JSON string unescaper with UTF-8 output
// Removes JSON escapes from a byte stream and encodes \u escapes as UTF-8.
// ----------------------------------------------------------------------------
// Usage:
// Bytes of a string body arrive on in_ch, one byte per request, with
// string_end marking the last byte. Decoded bytes leave on out_ch; each
// result carries byte_valid, escape_error, string_done (last result of the
// string) and run_last (last result produced by that input request).
// A result appears on out_ch the cycle after its input request is
// accepted. Throughput: one input request per cycle while out_ch is
// ready and each request yields at most one result. A request that
// yields two or three UTF-8 bytes holds the input while the single
// result register drains one byte per cycle to a ready out_ch. Requests
// that yield nothing (a backslash, a non-final hex digit) leave it empty.
// The next request is accepted in the same cycle that the last byte of the
// current bundle is taken, so the pipeline does not bubble.
// A stalled receiver holds the result register steady and, once the bundle
// is pending, backpressures in_ch.
// Reset (rst_n low, synchronous) empties the result register and returns
// the scanner to plain copy mode.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 (
  input logic     clk,
  input logic     rst_n,
  jsu_in_if.sink  in_ch,
  jsu_out_if.source out_ch
);
  import jsu_pkg::*;

  scan_state_t st_r;
  scan_state_t st_nxt;
  bundle_t     bun_r;
  bundle_t     bun_nxt;
  logic        full_r;
  logic [1:0]  idx_r;

  logic in_fire;
  logic out_fire;
  logic at_tail;

  jsu_decode u_decode (
    .st         (st_r),
    .char_in    (in_ch.char_in),
    .string_end (in_ch.string_end),
    .st_nxt     (st_nxt),
    .bun        (bun_nxt)
  );

  // The current entry is the final one of the bundle held in the register.
  assign at_tail  = (idx_r == bun_r.cnt - 2'd1);
  assign out_fire = out_ch.valid && out_ch.ready;
  assign in_fire  = in_ch.valid && in_ch.ready;

  // Take a new request when the result register is empty or is being
  // emptied by the receiver in this cycle.
  assign in_ch.ready = !full_r || (out_ch.ready && at_tail);

  assign out_ch.valid        = full_r;
  assign out_ch.out_byte     = bun_r.bytes[idx_r];
  assign out_ch.byte_valid   = bun_r.valid;
  assign out_ch.escape_error = bun_r.err;
  assign out_ch.run_last     = at_tail;
  assign out_ch.string_done  = at_tail && bun_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= '0;
      full_r <= 1'b0;
      idx_r  <= 2'd0;
    end else begin
      if (in_fire) begin
        st_r   <= st_nxt;
        full_r <= (bun_nxt.cnt != 2'd0);
        idx_r  <= 2'd0;
      end else if (out_fire) begin
        if (at_tail) begin
          full_r <= 1'b0;
          idx_r  <= 2'd0;
        end else begin
          idx_r <= idx_r + 2'd1;
        end
      end
    end
  end

  // Result payload needs no reset; full_r qualifies it.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      bun_r <= bun_nxt;
    end
  end

endmodule

// ===== rtl/jsu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_checker: port-level assertions for the JSON string unescaper
// Watches the output channel for flag consistency and stall behavior.
// ----------------------------------------------------------------------------
module jsu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic       escape_error,
  input logic       string_done,
  input logic       run_last
);

  // A result held against a stalled receiver stays offered, with its byte and run_last unchanged.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte)
      && $stable(run_last))
    else $error("result changed while stalled");

  // An error result carries no byte.
  a_err_nobyte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && escape_error |-> !byte_valid)
    else $error("error result flagged with a valid byte");

  // An error is always the only and last result of its request.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && escape_error |-> run_last)
    else $error("error result not last of its request");

  // The end of a string also closes the request's results.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && string_done |-> run_last)
    else $error("string_done without run_last");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_byte     (out_ch.out_byte),
  .byte_valid   (out_ch.byte_valid),
  .escape_error (out_ch.escape_error),
  .string_done  (out_ch.string_done),
  .run_last     (out_ch.run_last)
);

// ===== verif/json_string_unescape_utf8_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_tb: self-checking bench for the JSON unescaper
// Sends short escaped strings through the block: a directed set of corner
// strings first, then random strings that are mostly well formed. A
// behavioral decoder predicts every decoded byte, and a monitor checks each
// result against the oldest prediction. Both sides of the handshake idle at
// random, and the receiver also holds off for long stretches to fill the
// block and stall its input.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_tb;
  import jsu_pkg::*;

  // Output bytes of the single-letter escapes.
  localparam logic [7:0] BYTE_BSP = 8'h08;
  localparam logic [7:0] BYTE_FF  = 8'h0C;
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_TAB = 8'h09;

  // Code points at the borders of the UTF-8 length classes.
  localparam logic [15:0] CP_MARKS [6] = '{16'h0000, 16'h007F, 16'h0080,
                                           16'h07FF, 16'h0800, 16'hFFFF};

  // Cycles in which neither side idles, and the cycles at which the
  // receiver starts a long hold-off.
  localparam int CALM_START = 600;
  localparam int CALM_STOP  = 850;
  localparam int HOLD_AT_A  = 300;
  localparam int HOLD_AT_B  = 1000;
  localparam int HOLD_LEN   = 240;
  localparam int DRAIN_CYC  = 20;

  typedef struct packed {
    logic [7:0] ch;
    logic       tail;
  } raw_req_t;

  typedef struct packed {
    logic [7:0] data;
    logic       data_ok;
    logic       err;
    logic       done;
    logic       run_end;
  } result_t;

  logic clk;
  logic rst_n;

  jsu_in_if  in_ch ();
  jsu_out_if out_ch ();

  json_string_unescape_utf8 u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Requests waiting to be offered, and decoded bytes waiting to come out.
  raw_req_t raw_q [$];
  result_t  decoded_q [$];

  int total_reqs;
  int taken_reqs;
  int cyc;
  int fails;
  int hold_left;
  logic in_taken;

  // Own copy of the scanner state, updated on every accepted request.
  logic [1:0]  scan_md;
  logic [1:0]  hex_pos;
  logic [15:0] cp_acc;
  logic        hex_halt;
  logic        dropping;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Every input of the block is known from time zero.
  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.char_in = 8'h00;
    in_ch.string_end = 1'b0;
    out_ch.ready = 1'b0;
  end

  // Decode one hex digit; the return value says whether it was one.
  function automatic logic hex_nibble(input logic [7:0] c, output logic [3:0] v);
    v = 4'h0;
    if (c >= "0" && c <= "9") begin
      v = 4'(c - "0");
      return 1'b1;
    end
    if (c >= "a" && c <= "f") begin
      v = 4'(c - "a" + 10);
      return 1'b1;
    end
    if (c >= "A" && c <= "F") begin
      v = 4'(c - "A" + 10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Split a code point into its UTF-8 bytes; returns how many there are.
  function automatic int utf8_split(input logic [15:0] cp, output logic [2:0][7:0] seq);
    seq = '0;
    if (cp < 16'h0080) begin
      seq[0] = cp[7:0];
      return 1;
    end
    if (cp < 16'h0800) begin
      seq[0] = 8'hC0 | 8'(cp >> 6);
      seq[1] = 8'h80 | 8'(cp & 16'h003F);
      return 2;
    end
    seq[0] = 8'hE0 | 8'(cp >> 12);
    seq[1] = 8'h80 | 8'((cp >> 6) & 16'h003F);
    seq[2] = 8'h80 | 8'(cp & 16'h003F);
    return 3;
  endfunction

  function automatic void clear_scan();
    scan_md  = MODE_PLAIN;
    hex_pos  = 2'd0;
    cp_acc   = 16'h0000;
    hex_halt = 1'b0;
    dropping = 1'b0;
  endfunction

  // Work out the decoded bytes of one accepted request and queue them.
  task automatic decode_request(input logic [7:0] c, input logic tail);
    result_t r [3];
    logic [2:0][7:0] seq;
    logic [7:0] esc_byte;
    logic [3:0] nib;
    logic ok;
    int n;
    int cnt;
    n = 0;
    cnt = 0;
    esc_byte = 8'h00;
    ok = 1'b0;
    if (dropping) begin
      // After an error only the closing byte of the string says anything.
      if (tail) begin
        r[0] = '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0};
        n = 1;
      end
    end else if (scan_md == MODE_ESC) begin
      scan_md = MODE_PLAIN;
      ok = 1'b1;
      case (c)
        CH_QUOTE, CH_BSLASH, CH_SLASH: esc_byte = c;
        CH_B: esc_byte = BYTE_BSP;
        CH_F: esc_byte = BYTE_FF;
        CH_N: esc_byte = BYTE_LF;
        CH_R: esc_byte = BYTE_CR;
        CH_T: esc_byte = BYTE_TAB;
        CH_U: begin
          ok = 1'b0;
          scan_md = MODE_HEX;
          hex_pos = 2'd0;
          cp_acc = 16'h0000;
          hex_halt = 1'b0;
          // A 'u' that closes the string still yields code point zero.
          if (tail) cnt = utf8_split(16'h0000, seq);
        end
        default: begin
          ok = 1'b0;
          r[0] = '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0};
          n = 1;
          dropping = 1'b1;
        end
      endcase
      if (ok) begin
        r[0] = '{esc_byte, 1'b1, 1'b0, 1'b0, 1'b0};
        n = 1;
      end
    end else if (scan_md == MODE_HEX) begin
      ok = hex_nibble(c, nib);
      if (!hex_halt && ok) cp_acc = {cp_acc[11:0], nib};
      else hex_halt = 1'b1;
      // All four positions are consumed even after a non-hex byte.
      if (hex_pos == HEX_LAST_POS || tail) begin
        cnt = utf8_split(cp_acc, seq);
        scan_md = MODE_PLAIN;
        hex_pos = 2'd0;
        cp_acc = 16'h0000;
        hex_halt = 1'b0;
      end else begin
        hex_pos = hex_pos + 2'd1;
      end
    end else begin
      // Plain copy; the unused mode value behaves the same way.
      scan_md = MODE_PLAIN;
      if (c == CH_BSLASH) begin
        if (tail) begin
          r[0] = '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0};
          n = 1;
        end else begin
          scan_md = MODE_ESC;
        end
      end else begin
        r[0] = '{c, 1'b1, 1'b0, 1'b0, 1'b0};
        n = 1;
      end
    end
    for (int k = 0; k < cnt; k++) begin
      r[k] = '{seq[k], 1'b1, 1'b0, 1'b0, 1'b0};
    end
    if (cnt > 0) n = cnt;
    if (n > 0) begin
      r[n-1].run_end = 1'b1;
      r[n-1].done = tail;
    end
    if (tail) clear_scan();
    for (int k = 0; k < n; k++) decoded_q.insert(decoded_q.size(), r[k]);
  endtask

  task automatic push_req(input logic [7:0] c, input logic tail);
    raw_q.insert(raw_q.size(), '{c, tail});
  endtask

  // Queue a whole directed string; its last character closes it.
  task automatic queue_text(input string txt);
    for (int k = 0; k < txt.len(); k++) push_req(txt[k], k == txt.len() - 1);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v, input logic upper);
    if (v < 4'd10) return 8'("0" + v);
    return upper ? 8'("A" + v - 10) : 8'("a" + v - 10);
  endfunction

  // One random string: mostly well-formed tokens with random content, and
  // some noise, unknown escapes, trailing backslashes and cut-off endings.
  task automatic queue_random_string();
    logic [7:0] s [$];
    logic [7:0] c;
    logic [3:0] nib;
    logic [15:0] cp;
    int ntok;
    int kind;
    int stop_at;
    int keep;
    logic closed;
    ntok = $urandom_range(6, 1);
    closed = 1'b0;
    for (int t = 0; t < ntok && !closed; t++) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        s.insert(s.size(), 8'($urandom_range(255)));
      end else if (kind < 55) begin
        s.insert(s.size(), CH_BSLASH);
        case ($urandom_range(7))
          0: s.insert(s.size(), CH_QUOTE);
          1: s.insert(s.size(), CH_BSLASH);
          2: s.insert(s.size(), CH_SLASH);
          3: s.insert(s.size(), CH_B);
          4: s.insert(s.size(), CH_F);
          5: s.insert(s.size(), CH_N);
          6: s.insert(s.size(), CH_R);
          default: s.insert(s.size(), CH_T);
        endcase
      end else if (kind < 80) begin
        cp = ($urandom_range(1) == 0) ? CP_MARKS[$urandom_range(5)]
                                      : 16'($urandom_range(16'hFFFF));
        s.insert(s.size(), CH_BSLASH);
        s.insert(s.size(), CH_U);
        for (int d = 3; d >= 0; d--) begin
          s.insert(s.size(), hex_char(cp[d*4 +: 4], 1'($urandom_range(1))));
        end
      end else if (kind < 87) begin
        // A non-hex byte stops digit collection partway through.
        s.insert(s.size(), CH_BSLASH);
        s.insert(s.size(), CH_U);
        stop_at = $urandom_range(3);
        for (int d = 0; d < 4; d++) begin
          if (d == stop_at) begin
            do c = 8'($urandom_range(255)); while (hex_nibble(c, nib));
          end else if ($urandom_range(1) == 0) begin
            c = hex_char(4'($urandom_range(15)), 1'($urandom_range(1)));
          end else begin
            c = 8'($urandom_range(255));
          end
          s.insert(s.size(), c);
        end
      end else if (kind < 94) begin
        s.insert(s.size(), CH_BSLASH);
        do c = 8'($urandom_range(255));
        while (c inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U});
        s.insert(s.size(), c);
      end else begin
        s.insert(s.size(), CH_BSLASH);
        closed = 1'b1;
      end
    end
    // Now and then the string ends early, often inside an escape.
    keep = s.size();
    if ($urandom_range(9) == 0) keep = $urandom_range(s.size(), 1);
    for (int k = 0; k < keep; k++) push_req(s[k], k == keep - 1);
  endtask

  function automatic logic idle_now();
    if (cyc >= CALM_START && cyc < CALM_STOP) return 1'b0;
    return $urandom_range(99) < 38;
  endfunction

  // Cycle count and the record of accepted requests, both at the rising
  // edge; every accepted request is decoded here, in the order accepted.
  always @(posedge clk) begin
    cyc = cyc + 1;
    in_taken = rst_n && in_ch.valid && in_ch.ready;
    if (in_taken) begin
      decode_request(in_ch.char_in, in_ch.string_end);
      taken_reqs = taken_reqs + 1;
    end
  end

  // Sender: a request that is up stays up until it is taken; otherwise the
  // next one is offered unless this cycle is an idle one.
  always @(negedge clk) begin : drive_blk
    raw_req_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!(in_ch.valid && !in_taken)) begin
      if (raw_q.size() > 0 && !idle_now()) begin
        nxt = raw_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.char_in <= nxt.ch;
        in_ch.string_end <= nxt.tail;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random idling, plus two long hold-offs during which the
  // sender keeps offering so that the result register backs up the input.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (cyc == HOLD_AT_A || cyc == HOLD_AT_B) begin
      hold_left = HOLD_LEN - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !idle_now();
    end
  end

  // Monitor: each taken result is checked against the oldest prediction.
  always @(posedge clk) begin : watch_blk
    result_t got;
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.out_byte, out_ch.byte_valid, out_ch.escape_error,
              out_ch.string_done, out_ch.run_last};
      if (decoded_q.size() == 0) begin
        fails = fails + 1;
        $display("%0t: result with nothing expected: byte %h valid %b err %b done %b run %b",
                 $time, got.data, got.data_ok, got.err, got.done, got.run_end);
      end else begin
        want = decoded_q.pop_front();
        if (got !== want) begin
          fails = fails + 1;
          $display("%0t: expected byte %h valid %b err %b done %b run %b", $time,
                   want.data, want.data_ok, want.err, want.done, want.run_end);
          $display("%0t: actual   byte %h valid %b err %b done %b run %b", $time,
                   got.data, got.data_ok, got.err, got.done, got.run_end);
        end
      end
    end
  end

  initial begin
    cyc = 0;
    fails = 0;
    hold_left = 0;
    taken_reqs = 0;
    in_taken = 1'b0;
    clear_scan();

    // Directed strings: the byte extremes, the largest and a two-byte code
    // point, a hex run stopped by a non-hex byte and cut short, an unknown
    // escape with dropped bytes after it, a lone trailing backslash, a 'u'
    // closing the string, and two single-letter escapes.
    push_req(8'h00, 1'b0);
    push_req(8'hFF, 1'b1);
    queue_text("\\uFFFF");
    queue_text("\\u07FF");
    queue_text("\\u00z");
    queue_text("\\qab");
    queue_text("\\");
    queue_text("\\u");
    queue_text("\\t\\\"");

    while (raw_q.size() < 380) queue_random_string();
    total_reqs = raw_q.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (taken_reqs == total_reqs);
    wait (decoded_q.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);
    if (fails == 0 && decoded_q.size() == 0) begin
      $display("json_string_unescape_utf8_tb OK");
    end else begin
      $display("json_string_unescape_utf8_tb NOT OK");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("json_string_unescape_utf8_tb NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/jsu_pkg.sv
rtl/jsu_if.sv
rtl/jsu_decode.sv
rtl/json_string_unescape_utf8.sv
rtl/jsu_checker.sv
verif/json_string_unescape_utf8_tb.sv
